// ----- hw/rtl/mrb_pkg.sv -----
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared constants and types for the maximal rectangle core.
// ----------------------------------------------------------------------------
package mrb_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int HGT_W      = 11;   // column height, saturates at all ones
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int SIDE_W     = 11;
  localparam int AREA_W     = 21;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

  localparam logic [HGT_W-1:0] HGT_MAX = {HGT_W{1'b1}};

  // per-cell markers passed from front to back
  typedef struct packed {
    logic filled;
    logic first_row;
    logic last_col;
    logic last_row;
  } mrb_flags_t;

  localparam int FLAGS_W = $bits(mrb_flags_t);

endpackage

// ----- hw/rtl/mrb_ram.sv -----
// ----------------------------------------------------------------------------
// mrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mrb_queue.sv -----
// ----------------------------------------------------------------------------
// mrb_queue
// Small FIFO between the cell front end and the scan engine.
// ----------------------------------------------------------------------------
module mrb_queue #(
  parameter int Width = 8,
  parameter int Depth = mrb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [Width-1:0] rd_data
);

  localparam int PW = $clog2(Depth);

  logic [Width-1:0] slot_r [Depth];
  logic [PW-1:0]    wptr_r;
  logic [PW-1:0]    rptr_r;
  logic [PW:0]      count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != (PW+1)'(Depth));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(Depth-1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(Depth-1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(Depth))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wptr_r == rptr_r))
    else $error("queue empty with pointers apart");

  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && !clear) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count lost a pop");

endmodule

// ----- hw/rtl/mrb_front.sv -----
// ----------------------------------------------------------------------------
// mrb_front
// Holds the matrix size, tracks row and column of each cell and tags it.
// ----------------------------------------------------------------------------
module mrb_front #(
  parameter int MaxCols = mrb_pkg::MAX_COLS_DEF,
  parameter int MaxRows = mrb_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [mrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrb_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                         restart,
  input  logic                         in_valid,
  input  logic                         in_cell_req,
  input  logic                         q_ready,
  output logic                         q_valid,
  output logic [$clog2(MaxCols)-1:0]   q_col,
  output mrb_pkg::mrb_flags_t          q_flags
);

  localparam int CW = $clog2(MaxCols);
  localparam int RW = $clog2(MaxRows);

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] cols_last_r;
  logic [RW-1:0] rows_last_r;
  logic [CW-1:0] cols_last_nxt;
  logic [RW-1:0] rows_last_nxt;
  logic          take;

  // clamp the written size to 1..max and keep it as a last index
  always_comb begin
    if (cfg_wdata == '0) begin
      rows_last_nxt = '0;
      cols_last_nxt = '0;
    end else begin
      if (int'(cfg_wdata) > MaxRows) begin
        rows_last_nxt = RW'(MaxRows - 1);
      end else begin
        rows_last_nxt = RW'(cfg_wdata - 1'b1);
      end
      if (int'(cfg_wdata) > MaxCols) begin
        cols_last_nxt = CW'(MaxCols - 1);
      end else begin
        cols_last_nxt = CW'(cfg_wdata - 1'b1);
      end
    end
  end

  assign restart = cfg_valid &&
                   (cfg_index == mrb_pkg::CFG_ROW_COUNT || cfg_index == mrb_pkg::CFG_COL_COUNT);
  assign take    = in_valid && q_ready;

  assign q_valid           = in_valid;
  assign q_col             = col_r;
  assign q_flags.filled    = in_cell_req;
  assign q_flags.first_row = (row_r == '0);
  assign q_flags.last_col  = (col_r == cols_last_r);
  assign q_flags.last_row  = (row_r == rows_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cols_last_r <= '0;
      rows_last_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
      if (cfg_index == mrb_pkg::CFG_ROW_COUNT) begin
        rows_last_r <= rows_last_nxt;
      end else begin
        cols_last_r <= cols_last_nxt;
      end
    end else if (take) begin
      if (col_r == cols_last_r) begin
        col_r <= '0;
        row_r <= (row_r == rows_last_r) ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/mrb_back.sv -----
// ----------------------------------------------------------------------------
// mrb_back
// Histogram stack scan: updates column heights, pops and pushes the stack,
// scores each popped rectangle and emits the best one per matrix.
// ----------------------------------------------------------------------------
module mrb_back #(
  parameter int MaxCols = mrb_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                q_valid,
  input  logic [$clog2(MaxCols)-1:0]          q_col,
  input  mrb_pkg::mrb_flags_t                 q_flags,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mrb_pkg::SIDE_W-1:0]          out_short_side,
  output logic [mrb_pkg::SIDE_W-1:0]          out_long_side,
  output logic [mrb_pkg::AREA_W-1:0]          out_area
);

  localparam int HW = mrb_pkg::HGT_W;
  localparam int CW = $clog2(MaxCols);
  localparam int WW = CW + 1;
  localparam int AW = HW + WW;
  localparam int SW = (HW > WW) ? HW : WW;
  localparam int EW = CW + HW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HGT  = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]          state_r;
  logic [CW-1:0]       col_r;
  mrb_pkg::mrb_flags_t flags_r;
  logic [HW-1:0]       h_r;
  logic                flush_r;
  logic [WW-1:0]       depth_r;
  logic [HW-1:0]       top_h_r;
  logic [HW-1:0]       pop_h_r;
  logic [AW-1:0]       cand_area_r;
  logic [SW-1:0]       cand_s_r;
  logic [SW-1:0]       cand_l_r;
  logic [AW-1:0]       best_area_r;
  logic [SW-1:0]       best_s_r;
  logic [SW-1:0]       best_l_r;
  logic                out_valid_r;
  logic [mrb_pkg::SIDE_W-1:0] out_s_r;
  logic [mrb_pkg::SIDE_W-1:0] out_l_r;
  logic [mrb_pkg::AREA_W-1:0] out_a_r;

  logic [HW-1:0] hmem_rdata;
  logic [HW-1:0] h_nxt;
  logic [CW-1:0] hmem_raddr;
  logic [EW-1:0] smem_rdata;
  logic [CW-1:0] smem_raddr;
  logic          smem_we;
  logic          pop_cond;
  logic [WW-1:0] wref;
  logic [WW-1:0] wid;
  logic [SW-1:0] hext;
  logic [SW-1:0] wext;
  logic          better;

  mrb_ram #(.Width(HW), .Depth(MaxCols)) u_heights (
    .clk   (clk),
    .we    (state_r == S_HGT),
    .waddr (col_r),
    .wdata (h_nxt),
    .raddr (hmem_raddr),
    .rdata (hmem_rdata)
  );

  mrb_ram #(.Width(EW), .Depth(MaxCols)) u_stack (
    .clk   (clk),
    .we    (smem_we),
    .waddr (depth_r[CW-1:0]),
    .wdata ({col_r, h_r}),
    .raddr (smem_raddr),
    .rdata (smem_rdata)
  );

  assign hmem_raddr = q_col;
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  always_comb begin
    if (flags_r.first_row) begin
      h_nxt = HW'(flags_r.filled);
    end else if (!flags_r.filled) begin
      h_nxt = '0;
    end else if (hmem_rdata == mrb_pkg::HGT_MAX) begin
      h_nxt = hmem_rdata;
    end else begin
      h_nxt = hmem_rdata + 1'b1;
    end
  end

  assign pop_cond   = (depth_r != '0) && (flush_r || (top_h_r > h_r));
  assign smem_we    = (state_r == S_POP) && !pop_cond && !flush_r;
  // the entry below the one being popped becomes the new top
  assign smem_raddr = CW'(depth_r - 2'd2);
  assign wref       = flush_r ? ({1'b0, col_r} + 1'b1) : {1'b0, col_r};
  assign wid        = (depth_r == '0) ? wref
                                      : wref - {1'b0, smem_rdata[EW-1:HW]} - 1'b1;
  assign hext       = SW'(pop_h_r);
  assign wext       = SW'(wid);

  assign better = (cand_area_r != '0) &&
                  ((cand_area_r > best_area_r) ||
                   ((cand_area_r == best_area_r) &&
                    ((cand_l_r - cand_s_r) < (best_l_r - best_s_r))));

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          col_r   <= q_col;
          flags_r <= q_flags;
        end
      end
      S_HGT: h_r <= h_nxt;
      S_POP: begin
        if (pop_cond) begin
          pop_h_r <= top_h_r;
        end else if (!flush_r) begin
          top_h_r <= h_r;
        end
      end
      S_LOAD: begin
        if (depth_r != '0) begin
          top_h_r <= smem_rdata[HW-1:0];
        end
        cand_area_r <= AW'(pop_h_r) * AW'(wid);
        cand_s_r    <= (hext < wext) ? hext : wext;
        cand_l_r    <= (hext < wext) ? wext : hext;
      end
      default: ;
    endcase
    if (state_r == S_EMIT && !out_valid_r) begin
      out_s_r <= mrb_pkg::SIDE_W'(best_s_r);
      out_l_r <= mrb_pkg::SIDE_W'(best_l_r);
      out_a_r <= mrb_pkg::AREA_W'(best_area_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r     <= S_IDLE;
      flush_r     <= 1'b0;
      depth_r     <= '0;
      best_area_r <= '0;
      best_s_r    <= '0;
      best_l_r    <= '0;
      if (!rst_n) begin
        out_valid_r <= 1'b0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r <= S_HGT;
          end
        end
        S_HGT: begin
          flush_r <= 1'b0;
          state_r <= S_POP;
        end
        S_POP: begin
          if (pop_cond) begin
            depth_r <= depth_r - 1'b1;
            state_r <= S_LOAD;
          end else if (!flush_r) begin
            depth_r <= depth_r + 1'b1;
            if (flags_r.last_col) begin
              flush_r <= 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end else if (flags_r.last_row) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LOAD: state_r <= S_CMP;
        S_CMP: begin
          if (better) begin
            best_area_r <= cand_area_r;
            best_s_r    <= cand_s_r;
            best_l_r    <= cand_l_r;
          end
          state_r <= S_POP;
        end
        S_EMIT: begin
          // hold until the previous result is taken
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            best_area_r <= '0;
            best_s_r    <= '0;
            best_l_r    <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_short_side = out_s_r;
  assign out_long_side  = out_l_r;
  assign out_area       = out_a_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= WW'(MaxCols))
    else $error("stack depth beyond column count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (depth_r == '0))
    else $error("result emitted with columns left on the stack");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_valid && !restart) |=> (state_r == S_HGT))
    else $error("queued cell not started");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (cand_s_r <= cand_l_r))
    else $error("candidate sides out of order");

endmodule

// ----- hw/rtl/max_rectangle_binary_matrix_core.sv -----
// ----------------------------------------------------------------------------
// max_rectangle_binary_matrix_core
// Largest all-ones rectangle of a streamed binary matrix (histogram stack).
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_ready   | in_cell_req
//   out_    | out       | out_valid / out_ready | out_short_side, out_long_side, out_area
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// Each cell passes through the idle, height and pop states of the scan
// engine, and every stack pop adds a load and a compare state; each column
// is pushed and popped once per row, with registered height and stack RAMs.
// A 4-entry queue lets the front take cells while the engine pops.
// Reset is synchronous; the RAMs need no clearing pass. A stalled result
// holds the engine only at the end of a matrix.
// ----------------------------------------------------------------------------
module max_rectangle_binary_matrix_core #(
  parameter int MaxCols = mrb_pkg::MAX_COLS_DEF,
  parameter int MaxRows = mrb_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrb_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cell_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrb_pkg::SIDE_W-1:0]    out_short_side,
  output logic [mrb_pkg::SIDE_W-1:0]    out_long_side,
  output logic [mrb_pkg::AREA_W-1:0]    out_area
);

  localparam int CW = $clog2(MaxCols);
  localparam int QW = CW + mrb_pkg::FLAGS_W;

  logic                restart;
  logic                fq_valid;
  logic [CW-1:0]       fq_col;
  mrb_pkg::mrb_flags_t fq_flags;
  logic                bq_valid;
  logic                bq_pop;
  logic [QW-1:0]       bq_data;
  mrb_pkg::mrb_flags_t bq_flags;

  assign cfg_ready = 1'b1;

  mrb_front #(.MaxCols(MaxCols), .MaxRows(MaxRows)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .restart     (restart),
    .in_valid    (in_valid),
    .in_cell_req (in_cell_req),
    .q_ready     (in_ready),
    .q_valid     (fq_valid),
    .q_col       (fq_col),
    .q_flags     (fq_flags)
  );

  mrb_queue #(.Width(QW), .Depth(mrb_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (restart),
    .wr_valid (fq_valid),
    .wr_ready (in_ready),
    .wr_data  ({fq_flags, fq_col}),
    .rd_valid (bq_valid),
    .rd_pop   (bq_pop),
    .rd_data  (bq_data)
  );

  assign bq_flags = mrb_pkg::mrb_flags_t'(bq_data[QW-1:CW]);

  mrb_back #(.MaxCols(MaxCols)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (restart),
    .q_valid        (bq_valid),
    .q_col          (bq_data[CW-1:0]),
    .q_flags        (bq_flags),
    .q_pop          (bq_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_short_side (out_short_side),
    .out_long_side  (out_long_side),
    .out_area       (out_area)
  );

endmodule

// ----- dv/max_rectangle_binary_matrix_core_tb.sv -----
// ----------------------------------------------------------------------------
// max_rectangle_binary_matrix_core_tb
// Streams binary matrices into the core and checks the reported best
// rectangle against a histogram-stack scan kept inside the bench. Covers
// register extremes, clamping, ignored indexes, restart on write, and random
// matrices under several idle and stall mixes.
// ----------------------------------------------------------------------------
module max_rectangle_binary_matrix_core_tb;

  localparam int NCOLS     = mrb_pkg::MAX_COLS_DEF;
  localparam int NROWS     = mrb_pkg::MAX_ROWS_DEF;
  localparam int WDOG_MAX  = 60000;

  typedef struct {
    logic [mrb_pkg::SIDE_W-1:0] short_side;
    logic [mrb_pkg::SIDE_W-1:0] long_side;
    logic [mrb_pkg::AREA_W-1:0] area;
  } rect_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [mrb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mrb_pkg::CFG_W-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_cell_req;
  logic                          out_valid;
  logic                          out_ready;
  logic [mrb_pkg::SIDE_W-1:0]    out_short_side;
  logic [mrb_pkg::SIDE_W-1:0]    out_long_side;
  logic [mrb_pkg::AREA_W-1:0]    out_area;

  max_rectangle_binary_matrix_core dut (.*);

  // scan state mirrored in the bench
  int unsigned    run_hgt [NCOLS];
  int unsigned    col_stk [NCOLS];
  int unsigned    stk_top;
  longint         best_area;
  int unsigned    best_short, best_long;
  int unsigned    row_pos, col_pos;
  logic [mrb_pkg::CFG_W-1:0] rows_reg, cols_reg;

  rect_t          rect_q[$];
  int             mismatches;
  int             in_idle_pct, out_stall_pct;
  int             wdog;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_dim(logic [mrb_pkg::CFG_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void clear_scan();
    stk_top    = 0;
    best_area  = 0;
    best_short = 0;
    best_long  = 0;
    row_pos    = 0;
    col_pos    = 0;
  endfunction

  function automatic void weigh_rect(int unsigned hgt, int unsigned wid);
    longint      a;
    int unsigned s, l;
    a = longint'(hgt) * longint'(wid);
    s = (hgt < wid) ? hgt : wid;
    l = (hgt < wid) ? wid : hgt;
    if (a == 0) return;
    if (a > best_area || (a == best_area && (l - s) < (best_long - best_short))) begin
      best_area  = a;
      best_short = s;
      best_long  = l;
    end
  endfunction

  // advance the scan by one cell; queue a rectangle at the end of a matrix
  function automatic void scan_cell(logic filled);
    int unsigned cols, rows, c, h, hgt, wid;
    rect_t       r;
    cols = eff_dim(cols_reg, NCOLS);
    rows = eff_dim(rows_reg, NROWS);
    c = col_pos;
    if (c >= cols) c = 0;
    if (row_pos >= rows) row_pos = 0;
    if (row_pos == 0) h = filled;
    else if (!filled) h = 0;
    else begin
      h = run_hgt[c];
      if (h < mrb_pkg::HGT_MAX) h++;
    end
    run_hgt[c] = h;
    while (stk_top > 0 && run_hgt[col_stk[stk_top-1]] > h) begin
      stk_top--;
      hgt = run_hgt[col_stk[stk_top]];
      wid = (stk_top == 0) ? c : c - col_stk[stk_top-1] - 1;
      weigh_rect(hgt, wid);
    end
    if (stk_top < NCOLS) begin
      col_stk[stk_top] = c;
      stk_top++;
    end
    c++;
    if (c < cols) begin
      col_pos = c;
      return;
    end
    while (stk_top > 0) begin
      stk_top--;
      hgt = run_hgt[col_stk[stk_top]];
      wid = (stk_top == 0) ? cols : cols - col_stk[stk_top-1] - 1;
      weigh_rect(hgt, wid);
    end
    col_pos = 0;
    row_pos++;
    if (row_pos < rows) return;
    r.short_side = best_short[mrb_pkg::SIDE_W-1:0];
    r.long_side  = best_long[mrb_pkg::SIDE_W-1:0];
    r.area       = best_area[mrb_pkg::AREA_W-1:0];
    rect_q.push_back(r);
    clear_scan();
  endfunction

  // valid stays high on return; the caller drops it when the stream pauses
  task automatic send_cell(logic filled);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid    <= 1'b1;
    in_cell_req <= filled;
    do @(posedge clk); while (!(in_valid && in_ready));
    scan_cell(filled);
  endtask

  task automatic drop_in();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every rectangle, then let the engine drain queued cells
  task automatic settle(int unsigned cells);
    drop_in();
    while (rect_q.size() != 0) @(posedge clk);
    repeat (8 * cells + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic [mrb_pkg::CFG_IDX_W-1:0] idx,
                           logic [mrb_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == mrb_pkg::CFG_ROW_COUNT) rows_reg = val;
    else if (idx == mrb_pkg::CFG_COL_COUNT) cols_reg = val;
    else return;
    clear_scan();
  endtask

  task automatic set_shape(logic [mrb_pkg::CFG_W-1:0] rows, logic [mrb_pkg::CFG_W-1:0] cols);
    write_reg(mrb_pkg::CFG_ROW_COUNT, rows);
    write_reg(mrb_pkg::CFG_COL_COUNT, cols);
  endtask

  // one full matrix; fill_pct sets the share of filled cells
  task automatic send_matrix(int fill_pct);
    int unsigned n;
    n = eff_dim(rows_reg, NROWS) * eff_dim(cols_reg, NCOLS);
    repeat (n) send_cell($urandom_range(99) < fill_pct);
  endtask

  task automatic send_pattern(logic [mrb_pkg::CFG_W-1:0] rows, logic [mrb_pkg::CFG_W-1:0] cols,
                              logic [63:0] bits);
    set_shape(rows, cols);
    for (int i = 0; i < rows * cols; i++) send_cell(bits[i]);
    settle(rows * cols);
  endtask

  task automatic test_directed();
    send_pattern(3, 3, 64'h0);                 // no ones
    send_pattern(3, 3, 64'h1ff);               // all ones
    send_pattern(1, 1, 64'h1);
    // 2x2 block on a 1x4 strip: they join into a best 3x2 rectangle
    send_pattern(3, 4, 64'h0f3_3 >> 0);
    send_pattern(4, 4, 64'h0f0_0 | 64'h0033);
    send_pattern(2, 5, 64'b01110_11011);
  endtask

  task automatic test_config_edges();
    // zero acts as one
    set_shape(0, 0);
    send_cell(1'b1);
    settle(1);
    // ignored indexes leave the shape alone
    write_reg(2'd2, 11'h7ff);
    write_reg(2'd3, 11'h555);
    send_cell(1'b0);
    settle(1);
    // oversized shapes clamp to the maximum; stream the head of each
    set_shape(1, 11'h7ff);
    repeat (30) send_cell(1'($urandom_range(1)));
    settle(30);
    set_shape(11'h7ff, 1);
    repeat (30) send_cell(1'($urandom_range(1)));
    settle(30);
    // a write mid-matrix restarts the scan
    set_shape(4, 4);
    repeat (5) send_cell(1'b1);
    settle(5);
    write_reg(mrb_pkg::CFG_COL_COUNT, 3);
    send_matrix(70);
    settle(12);
  endtask

  task automatic test_random(int idle_pct, int stall_pct, int cells);
    int unsigned r, c, sent;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < cells) begin
      r = $urandom_range(1, 6);
      c = $urandom_range(1, 7);
      set_shape(mrb_pkg::CFG_W'(r), mrb_pkg::CFG_W'(c));
      send_matrix($urandom_range(3) == 0 ? $urandom_range(100) : $urandom_range(55, 95));
      sent += r * c;
      if ($urandom_range(3) == 0) begin
        // broken matrix, then a restart through a write
        repeat ($urandom_range(1, 4)) send_cell(1'($urandom_range(1)));
        settle(4);
      end else begin
        settle(r * c);
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    rect_t r;
    if (rst_n && out_valid && out_ready) begin
      if (rect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected rectangle: short %0d long %0d area %0d",
                   out_short_side, out_long_side, out_area);
      end else begin
        r = rect_q.pop_front();
        if (r.short_side !== out_short_side || r.long_side !== out_long_side ||
            r.area !== out_area) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rectangle mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                     r.short_side, r.long_side, r.area,
                     out_short_side, out_long_side, out_area);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_cell_req   = 1'b0;
    out_ready     = 1'b0;
    mismatches    = 0;
    wdog          = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rows_reg      = 1;
    cols_reg      = 1;
    foreach (run_hgt[i]) run_hgt[i] = 0;
    foreach (col_stk[i]) col_stk[i] = 0;
    clear_scan();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_edges();
    test_random(0, 0, 60);
    test_random(61, 0, 60);
    test_random(0, 61, 60);
    test_random(24, 24, 60);

    settle(8);
    if (mismatches == 0 && rect_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mrb_pkg.sv
hw/rtl/mrb_ram.sv
hw/rtl/mrb_queue.sv
hw/rtl/mrb_front.sv
hw/rtl/mrb_back.sv
hw/rtl/max_rectangle_binary_matrix_core.sv
dv/max_rectangle_binary_matrix_core_tb.sv
